[sv/spq_pkg.sv]
// Package for the sorted priority queue: sizes, codes and shared types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned STAT_W = 2;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } spq_kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } spq_status_e;

  // One stored entry
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } spq_entry_t;

  // Broadcast command from control to every cell
  typedef struct packed {
    logic       ins;
    logic       del;
    spq_entry_t entry;
  } spq_cmd_t;

endpackage

`default_nettype wire

[sv/spq_if.sv]
// Handshake channels of the sorted priority queue: operation in, result out.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_in_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [DATA_W-1:0] item_data;
  logic signed [PRIO_W-1:0] item_priority;

  modport source (output valid, kind, item_data, item_priority, input ready);
  modport sink   (input valid, kind, item_data, item_priority, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] removed_data;
  logic signed [PRIO_W-1:0] removed_priority;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, removed_data, removed_priority, occupancy,
                  input ready);
  modport sink   (input valid, status, removed_data, removed_priority, occupancy,
                  output ready);
endinterface

`default_nettype wire

[sv/spq_cell.sv]
// One slot of the sorted chain: holds an entry, compares it with the incoming
// priority and shifts toward its neighbors. Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire                      clk_i,
  input  wire spq_pkg::spq_cmd_t   cmd_i,
  input  wire                      live_i,        // slot index below entry count
  input  wire                      prev_keep_i,   // upper neighbor stays in place
  input  wire spq_pkg::spq_entry_t prev_entry_i,
  input  wire spq_pkg::spq_entry_t next_entry_i,
  output logic                     keep_o,
  output spq_pkg::spq_entry_t      entry_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;

  // Held entry outranks or ties the new one: it stays ahead
  assign keep_o = live_i && ($signed(entry_q.prio) >= $signed(cmd_i.entry.prio));

  // Insert: stay, take the new entry, or move down one; delete: move up one
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (keep_o) begin
        entry_d = entry_q;
      end else if (prev_keep_i) begin
        entry_d = cmd_i.entry;
      end else begin
        entry_d = prev_entry_i;
      end
    end else if (cmd_i.del) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[sv/sorted_priority_queue.sv]
// Top level of the sorted priority queue: chain of spq_cell slots, entry
// counter and result register. Depends on spq_pkg, spq_if and spq_cell.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    kind, item_data, item_priority
//   out_o    out  valid/ready    status, removed_data, removed_priority, occupancy
//
// One item per cycle unless out_o stalls; all slots compare with the new priority
// in parallel and shift in the same edge; the result is registered at acceptance.
// A result waiting on out_o stalls in_i only when out_o.ready is low.
// Reset clears the entry count and the result valid; slot contents are not reset.
`default_nettype none

module sorted_priority_queue (
  input  wire       clk_i,
  input  wire       rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             res_valid_q;
  logic [STAT_W-1:0] res_status_q;
  spq_status_e      status_d;
  spq_entry_t       res_entry_q, res_entry_d;
  logic [OCC_W-1:0] res_occ_q;

  logic             accept, full, empty;
  spq_cmd_t         cmd;
  logic       [DEPTH-1:0] keep;
  spq_entry_t [DEPTH-1:0] entries;

  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign accept = in_i.valid && in_i.ready;

  // Command broadcast to the chain
  always_comb begin
    cmd.ins        = accept && (in_i.kind == KIND_INSERT) && !full;
    cmd.del        = accept && (in_i.kind == KIND_DELETE) && !empty;
    cmd.entry.data = in_i.item_data;
    cmd.entry.prio = in_i.item_priority;
  end

  // Slot chain, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       live;
    logic       prev_keep;
    spq_entry_t prev_entry, next_entry;

    assign live = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_entry = cmd.entry;
    end else begin : g_body
      assign prev_keep  = keep[i-1];
      assign prev_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = cmd.entry;
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .live_i       (live),
      .prev_keep_i  (prev_keep),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .keep_o       (keep[i]),
      .entry_o      (entries[i])
    );
  end

  // Count update and result fields
  always_comb begin
    count_d     = count_q;
    status_d    = ST_OK;
    res_entry_d = '0;
    if (accept) begin
      case (in_i.kind)
        KIND_INSERT: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        KIND_DELETE: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            count_d     = count_q - CNT_W'(1);
            res_entry_d = entries[0];
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q <= status_d;
      res_entry_q  <= res_entry_d;
      res_occ_q    <= OCC_W'(count_d);
    end
  end

  assign in_i.ready             = !res_valid_q || out_o.ready;
  assign out_o.valid            = res_valid_q;
  assign out_o.status           = res_status_q;
  assign out_o.removed_data     = res_entry_q.data;
  assign out_o.removed_priority = res_entry_q.prio;
  assign out_o.occupancy        = res_occ_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_delete_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.del |=> res_entry_q == $past(entries[0]) && res_status_q == ST_OK)
    else $error("delete did not return the head entry");

  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.kind == KIND_DELETE && empty |=>
      res_status_q == ST_UNDERFLOW && count_q == '0)
    else $error("delete on empty not flagged");
`endif

endmodule

`default_nettype wire
